>>> hw/rtl/spm_pkg.sv
// Shared types and constants for the stream pattern masker.
// No dependencies; imported by every module of the block.
`default_nettype none

package spm_pkg;

  localparam int unsigned MAX_PATTERN_DEF   = 16;
  localparam int unsigned PATTERN_REG_BYTES = 16;
  localparam int unsigned LEN_REG_W         = 5;
  localparam int unsigned CFG_DATA_W        = 64;
  localparam int unsigned CFG_IDX_W         = 2;
  localparam logic [7:0]  ASTERISK          = 8'h2A;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PATTERN_LENGTH = 2'd0,
    REG_PATTERN_LOW    = 2'd1,
    REG_PATTERN_HIGH   = 2'd2
  } spm_reg_e;

  // per-cycle command from the sequencer to every window cell
  typedef struct packed {
    logic load;   // write the incoming byte into the cell at the fill point
    logic shift;  // move the window one place toward the oldest end
  } spm_cell_ctl_t;

endpackage

`default_nettype wire

>>> hw/rtl/spm_cell.sv
// One window cell: holds one byte, takes the new byte or its neighbor's byte,
// and compares against its pattern byte. Depends on spm_pkg.
`default_nettype none

module spm_cell #(
  parameter int unsigned LenW = 5,
  parameter int unsigned Idx  = 0
) (
  input  wire                   clk_i,
  input  spm_pkg::spm_cell_ctl_t ctl_i,
  input  wire [LenW-1:0]        fill_i,
  input  wire [LenW-1:0]        len_i,
  input  wire [7:0]             in_byte_i,
  input  wire [7:0]             pat_byte_i,
  input  wire [7:0]             right_i,
  output logic [7:0]            wnew_o,
  output logic                  hit_o
);
  import spm_pkg::*;

  logic [7:0] byte_q, byte_d;
  logic       at_fill;
  logic       unused;

  assign at_fill = (fill_i == LenW'(Idx));
  assign unused  = (LenW'(Idx) >= len_i);

  // window content after the new byte has been appended
  assign wnew_o = (ctl_i.load && at_fill) ? in_byte_i : byte_q;
  assign hit_o  = unused || (wnew_o == pat_byte_i);

  always_comb begin
    byte_d = ctl_i.shift ? right_i : wnew_o;
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
  end

endmodule

`default_nettype wire

>>> hw/rtl/spm_ctrl.sv
// Sequencer: fill count, pending asterisk / drain counters and output register.
// Depends on spm_pkg; drives the window cells.
`default_nettype none

module spm_ctrl #(
  parameter int unsigned LenW = 5
) (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire                    cfg_clr_i,
  input  wire [LenW-1:0]         len_i,
  input  wire                    in_valid_i,
  output logic                   in_ready_o,
  input  wire                    stream_end_i,
  input  wire [7:0]              oldest_i,
  input  wire                    match_all_i,
  output spm_pkg::spm_cell_ctl_t ctl_o,
  output logic [LenW-1:0]        fill_o,
  output logic                   out_valid_o,
  input  wire                    out_ready_i,
  output logic [7:0]             out_byte_o,
  output logic                   run_last_o,
  output logic                   stream_done_o
);
  import spm_pkg::*;

  logic [LenW-1:0] fill_q, fill_d;
  logic [LenW-1:0] ast_q, ast_d;
  logic [LenW-1:0] drain_q, drain_d;
  logic            last_q, last_d;
  logic            vld_q, vld_d;
  logic [7:0]      byte_q, byte_d;
  logic            rl_q, rl_d;
  logic            done_q, done_d;

  logic            idle, out_free, acc, full, match, emit;
  logic [LenW-1:0] fill_inc;

  assign idle       = (ast_q == '0) && (drain_q == '0);
  assign out_free   = !vld_q || out_ready_i;
  assign in_ready_o = idle && out_free;
  assign acc        = in_valid_i && in_ready_o;
  assign fill_inc   = fill_q + LenW'(1);
  assign full       = (fill_inc == len_i);
  assign match      = full && match_all_i;

  always_comb begin
    ctl_o   = '0;
    fill_d  = fill_q;
    ast_d   = ast_q;
    drain_d = drain_q;
    last_d  = last_q;
    emit    = 1'b0;
    byte_d  = byte_q;
    rl_d    = rl_q;
    done_d  = done_q;

    if (acc) begin
      ctl_o.load = 1'b1;
      last_d     = stream_end_i;
      if (match) begin
        emit   = 1'b1;
        byte_d = ASTERISK;
        ast_d  = len_i - LenW'(1);
        fill_d = '0;
        rl_d   = (len_i == LenW'(1));
        done_d = rl_d && stream_end_i;
      end else if (full || stream_end_i) begin
        // oldest word leaves now; on end of stream the rest drains after it
        ctl_o.shift = 1'b1;
        emit        = 1'b1;
        byte_d      = oldest_i;
        fill_d      = fill_q;
        drain_d     = stream_end_i ? fill_q : '0;
        rl_d        = !stream_end_i || (fill_q == '0);
        done_d      = rl_d && stream_end_i;
      end else begin
        fill_d = fill_inc;
      end
    end else if (!idle && out_free) begin
      emit = 1'b1;
      if (ast_q != '0) begin
        byte_d = ASTERISK;
        ast_d  = ast_q - LenW'(1);
        rl_d   = (ast_q == LenW'(1));
      end else begin
        ctl_o.shift = 1'b1;
        byte_d      = oldest_i;
        fill_d      = fill_q - LenW'(1);
        drain_d     = drain_q - LenW'(1);
        rl_d        = (drain_q == LenW'(1));
      end
      done_d = rl_d && last_q;
    end

    if (cfg_clr_i) begin
      fill_d = '0;
    end

    if (emit) begin
      vld_d = 1'b1;
    end else if (out_ready_i) begin
      vld_d = 1'b0;
    end else begin
      vld_d = vld_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q  <= '0;
      ast_q   <= '0;
      drain_q <= '0;
      last_q  <= 1'b0;
      vld_q   <= 1'b0;
    end else begin
      fill_q  <= fill_d;
      ast_q   <= ast_d;
      drain_q <= drain_d;
      last_q  <= last_d;
      vld_q   <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
    rl_q   <= rl_d;
    done_q <= done_d;
  end

  assign fill_o        = fill_q;
  assign out_valid_o   = vld_q;
  assign out_byte_o    = byte_q;
  assign run_last_o    = rl_q;
  assign stream_done_o = done_q;

endmodule

`default_nettype wire

>>> hw/rtl/stream_pattern_mask_top.sv
// Stream pattern masker: the first output word appears in the cycle after accept.
// Throughput 1 byte per cycle while the output is not stalled and each byte yields
// at most one word; a byte that completes a match or ends the stream holds the input
// until its words (up to the pattern length) have left the single output register.
// Reset: window empty, no words pending, length 1, pattern bytes zero.
// Holds configuration, the row of window cells and the sequencer; uses spm_pkg.
`default_nettype none

module stream_pattern_mask_top #(
  parameter int unsigned MAX_PATTERN = spm_pkg::MAX_PATTERN_DEF
) (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  input  wire                               cfg_valid_i,
  output logic                              cfg_ready_o,
  input  wire [spm_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  wire [spm_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  wire                               in_valid_i,
  output logic                              in_ready_o,
  input  wire [7:0]                         in_byte_i,
  input  wire                               stream_end_i,
  output logic                              out_valid_o,
  input  wire                               out_ready_i,
  output logic [7:0]                        out_byte_o,
  output logic                              run_last_o,
  output logic                              stream_done_o
);
  import spm_pkg::*;

  localparam int unsigned LenW   = $clog2(MAX_PATTERN + 1);
  localparam int unsigned LenLim = (MAX_PATTERN < PATTERN_REG_BYTES) ?
                                   MAX_PATTERN : PATTERN_REG_BYTES;

  logic [LEN_REG_W-1:0]  len_q, len_d;
  logic [CFG_DATA_W-1:0] pat_lo_q, pat_lo_d;
  logic [CFG_DATA_W-1:0] pat_hi_q, pat_hi_d;
  logic                  cfg_wr, len_wr;
  logic [LEN_REG_W-1:0]  len_sat;
  logic [LenW-1:0]       eff_len;
  logic [LenW-1:0]       fill;
  spm_cell_ctl_t         ctl;
  logic [7:0]            pat   [MAX_PATTERN];
  logic [7:0]            wnew  [MAX_PATTERN];
  logic [7:0]            right [MAX_PATTERN];
  logic [MAX_PATTERN-1:0] hits;

  // configuration
  assign cfg_ready_o = 1'b1;
  assign cfg_wr      = cfg_valid_i && cfg_ready_o;

  always_comb begin
    len_d    = len_q;
    pat_lo_d = pat_lo_q;
    pat_hi_d = pat_hi_q;
    len_wr   = 1'b0;
    if (cfg_wr) begin
      unique case (cfg_index_i)
        REG_PATTERN_LENGTH: begin
          len_d  = cfg_data_i[LEN_REG_W-1:0];
          len_wr = 1'b1;
        end
        REG_PATTERN_LOW:  pat_lo_d = cfg_data_i;
        REG_PATTERN_HIGH: pat_hi_d = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q    <= LEN_REG_W'(1);
      pat_lo_q <= '0;
      pat_hi_q <= '0;
    end else begin
      len_q    <= len_d;
      pat_lo_q <= pat_lo_d;
      pat_hi_q <= pat_hi_d;
    end
  end

  always_comb begin
    if (len_q == '0) begin
      len_sat = LEN_REG_W'(1);
    end else if (len_q > LEN_REG_W'(LenLim)) begin
      len_sat = LEN_REG_W'(LenLim);
    end else begin
      len_sat = len_q;
    end
  end
  assign eff_len = LenW'(len_sat);

  // row of window cells, cell 0 holds the oldest byte
  for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
    if (k < 8) begin : g_lo
      assign pat[k] = pat_lo_q[8*k +: 8];
    end else if (k < PATTERN_REG_BYTES) begin : g_hi
      assign pat[k] = pat_hi_q[8*(k-8) +: 8];
    end else begin : g_none
      assign pat[k] = 8'h00;
    end

    if (k == MAX_PATTERN - 1) begin : g_end
      assign right[k] = 8'h00;
    end else begin : g_mid
      assign right[k] = wnew[k+1];
    end

    spm_cell #(
      .LenW (LenW),
      .Idx  (k)
    ) u_cell (
      .clk_i      (clk_i),
      .ctl_i      (ctl),
      .fill_i     (fill),
      .len_i      (eff_len),
      .in_byte_i  (in_byte_i),
      .pat_byte_i (pat[k]),
      .right_i    (right[k]),
      .wnew_o     (wnew[k]),
      .hit_o      (hits[k])
    );
  end

  spm_ctrl #(
    .LenW (LenW)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_clr_i     (len_wr),
    .len_i         (eff_len),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .stream_end_i  (stream_end_i),
    .oldest_i      (wnew[0]),
    .match_all_i   (&hits),
    .ctl_o         (ctl),
    .fill_o        (fill),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_byte_o    (out_byte_o),
    .run_last_o    (run_last_o),
    .stream_done_o (stream_done_o)
  );

`ifndef ASSERT_OFF
  a_fill_below_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill < eff_len)
    else $error("window fill reached pattern length");

  a_done_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && stream_done_o) |-> run_last_o)
    else $error("stream_done without run_last");

  a_done_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && stream_done_o) |-> (fill == '0))
    else $error("window not empty at end of stream");
`endif

endmodule

`default_nettype wire
